/* hdl/diff_drive_mixer_slew_limit_top_macros.svh */
// Assertion macros shared by the slew stage and the top level.
// Each assertion is clocked by clk and disabled while arst_n is low.
// Defining ASSERT_OFF turns every assertion into empty text.
`ifndef DIFF_DRIVE_MIXER_SLEW_LIMIT_TOP_MACROS_SVH
`define DIFF_DRIVE_MIXER_SLEW_LIMIT_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

/* hdl/ddmsl_pkg.sv */
// Types, constants and arithmetic helpers of the differential drive mixer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ddmsl_pkg;

	// Fixed-point formats.
	localparam int FRAC_BITS = 14;
	localparam int RATE_FRAC = 24;
	localparam int RATE_W = 20;
	localparam int LIM_W = 16;
	localparam int LIM_SHIFT = RATE_FRAC - FRAC_BITS;

	localparam logic signed [16:0] SUM_ONE = 17'sd1 <<< FRAC_BITS;
	localparam logic signed [15:0] DRIVE_ONE = 16'sd1 <<< FRAC_BITS;
	localparam logic [14:0] SCALE_ONE = 15'd1 << FRAC_BITS;
	localparam logic [25:0] LIM_CAP = 26'd2 << RATE_FRAC;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE = 1'd1;
	localparam logic [RATE_W-1:0] RATE_RESET = 20'd16777;

	typedef struct packed {
		logic motion_req;
		logic source_is_none;
		logic signed [15:0] forward;
		logic signed [15:0] turn;
		logic [14:0] speed_scale;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic enable;
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
		logic left_neg;
		logic right_neg;
	} out_word_t;

	// Input register contents: command plus elapsed time.
	typedef struct packed {
		logic stop;
		logic signed [15:0] forward;
		logic signed [15:0] turn;
		logic [14:0] scale;
		logic [31:0] dt;
	} s1_t;

	// Scaled targets and both step limits.
	typedef struct packed {
		logic stop;
		logic signed [15:0] left_tgt;
		logic signed [15:0] right_tgt;
		logic [LIM_W-1:0] rise_lim;
		logic [LIM_W-1:0] fall_lim;
	} s2_t;

	// Clamp a mixed sum to plus or minus one.
	function automatic logic signed [15:0] clamp_unit(input logic signed [16:0] v);
		logic signed [16:0] c;
		if (v > SUM_ONE) begin
			c = SUM_ONE;
		end else if (v < -SUM_ONE) begin
			c = -SUM_ONE;
		end else begin
			c = v;
		end
		return c[15:0];
	endfunction

	// Scale the magnitude, truncating toward zero, then restore the sign.
	function automatic logic signed [15:0] scale_side(input logic signed [15:0] v,
			input logic [14:0] scale);
		logic [14:0] mag;
		logic [29:0] prod;
		logic [14:0] p;
		logic signed [15:0] ps;
		mag = v[15] ? 15'(-v) : 15'(v);
		prod = 30'(mag) * 30'(scale);
		p = 15'(prod >> FRAC_BITS);
		ps = $signed({1'b0, p});
		return v[15] ? -ps : ps;
	endfunction

	// Rate times elapsed milliseconds, saturated at 2.0, in drive units.
	function automatic logic [LIM_W-1:0] step_limit(input logic [RATE_W-1:0] rate,
			input logic [31:0] dt);
		logic [51:0] raw;
		logic [25:0] sat;
		raw = 52'(rate) * 52'(dt);
		sat = (raw > 52'(LIM_CAP)) ? LIM_CAP : raw[25:0];
		return LIM_W'(sat >> LIM_SHIFT);
	endfunction

	// Move from the previous drive toward the target by at most the limit.
	function automatic logic signed [15:0] slew_side(input logic signed [15:0] tgt,
			input logic signed [15:0] prev, input logic [LIM_W-1:0] rise_lim,
			input logic [LIM_W-1:0] fall_lim);
		logic [15:0] at;
		logic [15:0] ap;
		logic [LIM_W-1:0] lim;
		logic signed [17:0] d;
		logic signed [17:0] l18;
		logic signed [17:0] r;
		at = tgt[15] ? 16'(-tgt) : 16'(tgt);
		ap = prev[15] ? 16'(-prev) : 16'(prev);
		lim = (at > ap) ? rise_lim : fall_lim;
		d = 18'(tgt) - 18'(prev);
		l18 = $signed({2'b00, lim});
		if (d > l18) begin
			r = 18'(prev) + l18;
		end else if (d < -l18) begin
			r = 18'(prev) - l18;
		end else begin
			r = 18'(tgt);
		end
		return r[15:0];
	endfunction

endpackage

/* hdl/ddmsl_mix.sv */
// Mixing stage: clamp, speed scaling and step limit products, registered.
// Depends on ddmsl_pkg.
`timescale 1ns / 1ps

module ddmsl_mix (
	input logic clk,
	input logic arst_n,
	input logic s1_valid,
	input logic adv,
	input ddmsl_pkg::s1_t s1,
	input logic [ddmsl_pkg::RATE_W-1:0] rise_rate,
	input logic [ddmsl_pkg::RATE_W-1:0] fall_rate,
	output logic s2_valid,
	output ddmsl_pkg::s2_t s2
);
	import ddmsl_pkg::*;

	logic signed [15:0] fwd;
	logic signed [15:0] trn;
	logic signed [16:0] sum_l;
	logic signed [16:0] sum_r;
	logic [14:0] scale_eff;
	s2_t s2_d;

	// Mix forward and turn, clamp each side, apply the speed scale and work out the step limits.
	always_comb begin
		fwd = s1.forward;
		trn = s1.turn;
		sum_l = 17'(fwd) + 17'(trn);
		sum_r = 17'(fwd) - 17'(trn);
		scale_eff = (s1.scale > SCALE_ONE) ? SCALE_ONE : s1.scale;
		s2_d.stop = s1.stop;
		s2_d.left_tgt = scale_side(clamp_unit(sum_l), scale_eff);
		s2_d.right_tgt = scale_side(clamp_unit(sum_r), scale_eff);
		s2_d.rise_lim = step_limit(rise_rate, s1.dt);
		s2_d.fall_lim = step_limit(fall_rate, s1.dt);
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			s2 <= s2_d;
		end
	end

endmodule

/* hdl/ddmsl_slew.sv */
// Slew stage: limits each side against its previous drive, holds the result word.
// Depends on ddmsl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "diff_drive_mixer_slew_limit_top_macros.svh"

module ddmsl_slew (
	input logic clk,
	input logic arst_n,
	input logic s2_valid,
	input logic adv,
	input ddmsl_pkg::s2_t s2,
	output logic out_valid,
	output ddmsl_pkg::out_word_t out_word
);
	import ddmsl_pkg::*;

	logic signed [15:0] prev_left_q;
	logic signed [15:0] prev_right_q;
	logic signed [15:0] left_nxt;
	logic signed [15:0] right_nxt;
	out_word_t word_d;
	logic word_zero;
	logic word_sign_ok;
	logic word_in_range;

	// Slew limit both sides; a stop word drives zero.
	always_comb begin
		left_nxt = slew_side(s2.left_tgt, prev_left_q, s2.rise_lim, s2.fall_lim);
		right_nxt = slew_side(s2.right_tgt, prev_right_q, s2.rise_lim, s2.fall_lim);
		if (s2.stop) begin
			left_nxt = '0;
			right_nxt = '0;
		end
		word_d.enable = !s2.stop;
		word_d.left_drive = left_nxt;
		word_d.right_drive = right_nxt;
		word_d.left_neg = left_nxt[15];
		word_d.right_neg = right_nxt[15];
	end

	// Previous drive state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			prev_left_q <= '0;
			prev_right_q <= '0;
		end else if (adv) begin
			out_valid <= s2_valid;
			if (s2_valid) begin
				prev_left_q <= left_nxt;
				prev_right_q <= right_nxt;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (adv && s2_valid) begin
			out_word <= word_d;
		end
	end

	// Properties of the held result word.
	assign word_zero = (out_word.left_drive == '0) && (out_word.right_drive == '0);
	assign word_sign_ok = (out_word.left_neg == out_word.left_drive[15])
		&& (out_word.right_neg == out_word.right_drive[15]);
	assign word_in_range = (out_word.left_drive <= DRIVE_ONE)
		&& (out_word.left_drive >= -DRIVE_ONE)
		&& (out_word.right_drive <= DRIVE_ONE)
		&& (out_word.right_drive >= -DRIVE_ONE);

	`ASSERT_IMP(a_stop_zero, out_valid && !out_word.enable, word_zero, "stop with drive")
	`ASSERT_IMP(a_rev_sign, out_valid, word_sign_ok, "reverse flag disagrees with sign")
	`ASSERT_IMP(a_drive_range, out_valid, word_in_range, "drive beyond full scale")

endmodule

/* hdl/diff_drive_mixer_slew_limit_top.sv */
// Top level of the differential drive mixer with slew rate limiter.
// Depends on ddmsl_pkg, ddmsl_mix, ddmsl_slew and the assertion macro header.
//
// Channel   Direction  Handshake            Payload
// in        in         in_valid/in_stall    in_word   (command word)
// out       out        out_valid/out_stall  out_word  (drive word)
// cfg       in         cfg_we               cfg_index, cfg_data (rise/fall rate)
//
// One word per cycle is accepted while in_stall is low; its result passes through the
// input, mix and result registers in that order.
// The slew stage reads the previous drive in the cycle it writes it, so words
// follow each other without gaps.
// Reset clears all pipeline valids, drive state and timing; both rates reset to 16777.
// out_stall holds the result register; in_stall rises only when every stage is
// full and the result is held.
`timescale 1ns / 1ps
`include "diff_drive_mixer_slew_limit_top_macros.svh"

module diff_drive_mixer_slew_limit_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ddmsl_pkg::in_word_t in_word,
	output logic out_valid,
	input logic out_stall,
	output ddmsl_pkg::out_word_t out_word,
	input logic cfg_we,
	input logic [ddmsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ddmsl_pkg::RATE_W-1:0] cfg_data
);
	import ddmsl_pkg::*;

	logic [RATE_W-1:0] rise_rate_q;
	logic [RATE_W-1:0] fall_rate_q;
	logic started_q;
	logic [31:0] last_time_q;
	logic s1_valid_s1;
	s1_t s1_s1;
	s1_t s1_d;
	logic s2_valid;
	s2_t s2;
	logic out_go;
	logic s2_go;
	logic s1_go;
	logic accept;

	// Pipeline advance: a stage moves when the next one is empty or moving.
	assign out_go = !out_valid || !out_stall;
	assign s2_go = !s2_valid || out_go;
	assign s1_go = !s1_valid_s1 || s2_go;
	assign in_stall = !s1_go;
	assign accept = in_valid && s1_go;

	// Decode the stop request and the elapsed time at accept.
	always_comb begin
		s1_d.stop = !in_word.motion_req || in_word.source_is_none
			|| (in_word.speed_scale == '0);
		s1_d.forward = in_word.forward;
		s1_d.turn = in_word.turn;
		s1_d.scale = in_word.speed_scale;
		s1_d.dt = started_q ? (in_word.now_ms - last_time_q) : '0;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_rate_q <= RATE_RESET;
			fall_rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RISE_RATE: rise_rate_q <= cfg_data;
				REG_FALL_RATE: fall_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Timing state follows accepted words in order; a stop clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			last_time_q <= '0;
		end else if (accept) begin
			if (s1_d.stop) begin
				started_q <= 1'b0;
				last_time_q <= '0;
			end else begin
				started_q <= 1'b1;
				last_time_q <= in_word.now_ms;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_go) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	ddmsl_mix u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.s1_valid(s1_valid_s1),
		.adv(s2_go),
		.s1(s1_s1),
		.rise_rate(rise_rate_q),
		.fall_rate(fall_rate_q),
		.s2_valid(s2_valid),
		.s2(s2)
	);

	ddmsl_slew u_slew (
		.clk(clk),
		.arst_n(arst_n),
		.s2_valid(s2_valid),
		.adv(out_go),
		.s2(s2),
		.out_valid(out_valid),
		.out_word(out_word)
	);

	`ASSERT_IMP(a_stall_full, in_stall, s1_valid_s1 && s2_valid && out_valid, "stall, free stage")
	`ASSERT_IMP(a_no_stall_empty, !out_valid, !in_stall, "stall with empty result register")
	`ASSERT_NXT(a_first_dt, accept && !started_q, s1_s1.dt == '0, "first word has elapsed time")

endmodule

/* sim/tb_diff_drive_mixer_slew_limit_top.sv */
// Self-checking testbench for the differential drive mixer with slew rate limiter.
// Depends on ddmsl_pkg and diff_drive_mixer_slew_limit_top; needs no files or arguments.
// A scoreboard predicts every drive word from the command words and compares in order.
`timescale 1ns / 1ps

module tb_diff_drive_mixer_slew_limit_top;
	import ddmsl_pkg::*;

	// Tracks rates and slew state, and holds the drive words still to come.
	class drive_scoreboard;
		logic [RATE_W-1:0] rise_rate;
		logic [RATE_W-1:0] fall_rate;
		logic started;
		logic [31:0] last_ms;
		longint prev_left;
		longint prev_right;
		out_word_t drive_q[$];
		int errors;

		function new();
			rise_rate = RATE_RESET;
			fall_rate = RATE_RESET;
			started = 1'b0;
			last_ms = '0;
			prev_left = 0;
			prev_right = 0;
			errors = 0;
		endfunction

		// Limit a mixed sum to plus or minus one.
		function longint clamp_one(longint v);
			longint one;
			one = longint'(1) << FRAC_BITS;
			if (v > one) begin
				return one;
			end else if (v < -one) begin
				return -one;
			end
			return v;
		endfunction

		// Scale the magnitude with truncation, then put the sign back.
		function longint scale_mag(longint v, longint s);
			longint m;
			m = ((v < 0 ? -v : v) * s) >>> FRAC_BITS;
			return (v < 0) ? -m : m;
		endfunction

		// Move toward the target by at most rate times elapsed time.
		function longint slew(longint tgt, longint prev, longint dt);
			longint at;
			longint ap;
			longint raw;
			longint lim;
			at = (tgt < 0) ? -tgt : tgt;
			ap = (prev < 0) ? -prev : prev;
			raw = ((at > ap) ? longint'(rise_rate) : longint'(fall_rate)) * dt;
			if (raw > (longint'(2) << RATE_FRAC)) begin
				raw = longint'(2) << RATE_FRAC;
			end
			lim = raw >>> (RATE_FRAC - FRAC_BITS);
			if (tgt - prev > lim) begin
				return prev + lim;
			end else if (tgt - prev < -lim) begin
				return prev - lim;
			end
			return tgt;
		endfunction

		// Work out the drive word that an accepted command word causes.
		function void note_input(in_word_t w);
			out_word_t e;
			longint s;
			longint l;
			longint r;
			logic [31:0] dt;
			e = '0;
			if (!w.motion_req || w.source_is_none || w.speed_scale == 0) begin
				started = 1'b0;
				last_ms = '0;
				prev_left = 0;
				prev_right = 0;
			end else begin
				s = longint'(w.speed_scale);
				if (s > (longint'(1) << FRAC_BITS)) begin
					s = longint'(1) << FRAC_BITS;
				end
				l = scale_mag(clamp_one(longint'($signed(w.forward)) +
					longint'($signed(w.turn))), s);
				r = scale_mag(clamp_one(longint'($signed(w.forward)) -
					longint'($signed(w.turn))), s);
				if (!started) begin
					started = 1'b1;
					last_ms = w.now_ms;
				end
				dt = w.now_ms - last_ms;
				l = slew(l, prev_left, longint'({32'd0, dt}));
				r = slew(r, prev_right, longint'({32'd0, dt}));
				prev_left = l;
				prev_right = r;
				last_ms = w.now_ms;
				e.enable = 1'b1;
				e.left_drive = l[15:0];
				e.right_drive = r[15:0];
				e.left_neg = (l < 0);
				e.right_neg = (r < 0);
			end
			drive_q.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		// Compare one accepted drive word with the oldest prediction.
		task check_result(out_word_t got);
			out_word_t e;
			if (drive_q.size() == 0) begin
				report("drive word with no prediction pending");
			end else begin
				e = drive_q.pop_front();
				if (got.enable !== e.enable) begin
					report($sformatf("enable %b, expected %b", got.enable, e.enable));
				end
				if (got.left_drive !== e.left_drive) begin
					report($sformatf("left_drive %0d, expected %0d",
						got.left_drive, e.left_drive));
				end
				if (got.right_drive !== e.right_drive) begin
					report($sformatf("right_drive %0d, expected %0d",
						got.right_drive, e.right_drive));
				end
				if (got.left_neg !== e.left_neg) begin
					report($sformatf("left_neg %b, expected %b",
						got.left_neg, e.left_neg));
				end
				if (got.right_neg !== e.right_neg) begin
					report($sformatf("right_neg %b, expected %b",
						got.right_neg, e.right_neg));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_RISE_RATE;
	logic [RATE_W-1:0] cfg_data = '0;

	drive_scoreboard score;
	int in_count = 0;
	logic quiet;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic [31:0] clock_ms = '0;
	logic signed [15:0] cmd_fwd = '0;
	logic signed [15:0] cmd_trn = '0;

	diff_drive_mixer_slew_limit_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both sides run without gaps over a stretch of words.
	assign quiet = (in_count >= 150) && (in_count < 250);

	// Receiver stalls: random, one long hold-off, and none in the quiet stretch.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && in_count >= 320) begin
			hold_done <= 1'b1;
			hold_left <= 60;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 12);
		end
	end

	// Every accepted drive word is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			score.check_result(out_word);
		end
	end

	// Offer one command word, with an occasional gap before it.
	task automatic send_word(input in_word_t w);
		if (!quiet && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		score.note_input(w);
		in_count++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic req, input logic none,
			input logic signed [15:0] fwd, input logic signed [15:0] trn,
			input logic [14:0] scale, input logic [31:0] now);
		in_word_t w;
		w.motion_req = req;
		w.source_is_none = none;
		w.forward = fwd;
		w.turn = trn;
		w.speed_scale = scale;
		w.now_ms = now;
		send_word(w);
	endtask

	// Stop offering, wait until every prediction is met, then let the pipe empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (score.drive_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
	endtask

	// Write both rate registers on back-to-back cycles.
	task automatic write_rates(input logic [RATE_W-1:0] rise, input logic [RATE_W-1:0] fall);
		cfg_we <= 1'b1;
		cfg_index <= REG_RISE_RATE;
		cfg_data <= rise;
		@(negedge clk);
		cfg_index <= REG_FALL_RATE;
		cfg_data <= fall;
		@(negedge clk);
		cfg_we <= 1'b0;
		score.rise_rate = rise;
		score.fall_rate = fall;
	endtask

	// Mostly in-range commands, sometimes any 16-bit value or an extreme.
	function automatic logic signed [15:0] random_drive();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return 16'(int'($urandom_range(0, 32768)) - 16384);
		end else if (pick < 8) begin
			return 16'($urandom);
		end
		case ($urandom_range(0, 4))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sh7fff;
			3: return 16'sh8000;
			default: return 16'sd0;
		endcase
	endfunction

	// Mostly steady driving with advancing time; some stops and some noise.
	function automatic in_word_t make_cmd();
		in_word_t w;
		int pick;
		int sp;
		int tp;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 30) begin
			cmd_fwd = random_drive();
			cmd_trn = random_drive();
		end
		tp = $urandom_range(0, 99);
		if (tp < 70) begin
			clock_ms = clock_ms + $urandom_range(1, 30);
		end else if (tp < 95 && tp >= 77) begin
			clock_ms = clock_ms + $urandom_range(31, 3000);
		end else if (tp >= 95) begin
			clock_ms = clock_ms + $urandom;
		end
		sp = $urandom_range(0, 9);
		w.motion_req = 1'b1;
		w.source_is_none = 1'b0;
		w.forward = cmd_fwd;
		w.turn = cmd_trn;
		if (sp < 8) begin
			w.speed_scale = 15'($urandom_range(1, 16384));
		end else if (sp == 8) begin
			w.speed_scale = SCALE_ONE;
		end else begin
			w.speed_scale = 15'($urandom_range(16385, 32767));
		end
		w.now_ms = clock_ms;
		if (pick >= 96) begin
			w.motion_req = 1'($urandom);
			w.source_is_none = 1'($urandom);
			w.forward = 16'($urandom);
			w.turn = 16'($urandom);
			w.speed_scale = 15'($urandom);
			w.now_ms = $urandom;
			clock_ms = w.now_ms;
		end else if (pick >= 93) begin
			w.speed_scale = '0;
		end else if (pick >= 90) begin
			w.source_is_none = 1'b1;
		end else if (pick >= 87) begin
			w.motion_req = 1'b0;
		end
		return w;
	endfunction

	// Reset, directed words, then random phases under several rate settings.
	initial begin
		score = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				// First driven word holds at zero; then a normal rise.
				send_fields(1'b1, 1'b0, 16'sd16384, 16'sd0, 15'd16384, 32'd1000);
				send_fields(1'b1, 1'b0, 16'sd16384, 16'sd0, 15'd16384, 32'd1010);
				// Sums far outside one and scale above one, the second with no elapsed time.
				send_fields(1'b1, 1'b0, 16'sh8000, 16'sh8000, 15'h7fff, 32'd1020);
				send_fields(1'b1, 1'b0, 16'sh7fff, 16'sh7fff, 15'h7fff, 32'd1020);
				send_fields(1'b1, 1'b0, 16'sd0, 16'sd16384, 15'd1, 32'd1030);
				// A long gap lets the limit saturate.
				send_fields(1'b1, 1'b0, -16'sd16384, 16'sd16384, 15'd16384, 32'd101030);
				send_fields(1'b1, 1'b0, 16'sd16384, 16'sd16384, 15'd16384, 32'hffff_fff0);
				// Timestamp wraps past zero.
				send_fields(1'b1, 1'b0, 16'sd16384, -16'sd16384, 15'd16384, 32'h0000_0010);
				// Each way of stopping, and restart after a stop.
				send_fields(1'b0, 1'b0, 16'sd5000, 16'sd1000, 15'd16384, 32'd20);
				send_fields(1'b1, 1'b0, 16'sd8000, -16'sd3000, 15'd12000, 32'd5);
				send_fields(1'b1, 1'b0, 16'sd8000, -16'sd3000, 15'd12000, 32'd405);
				send_fields(1'b1, 1'b1, 16'sd8000, -16'sd3000, 15'd12000, 32'd410);
				send_fields(1'b1, 1'b0, 16'sd8000, -16'sd3000, 15'd12000, 32'd420);
				send_fields(1'b0, 1'b1, 16'sd8000, -16'sd3000, 15'd12000, 32'd430);
				send_fields(1'b1, 1'b0, -16'sd16384, -16'sd16384, 15'd16384, 32'd100);
				send_fields(1'b1, 1'b0, -16'sd16384, -16'sd16384, 15'd16384, 32'd132);
				send_fields(1'b1, 1'b0, -16'sd16384, -16'sd16384, 15'd0, 32'd140);
				send_fields(1'b1, 1'b0, -16'sd16384, 16'sd0, 15'd16384, 32'd150);
				send_fields(1'b1, 1'b0, 16'sd16384, 16'sd16384, 15'd16384, 32'hffff_ffff);
				send_fields(1'b1, 1'b0, -16'sd16384, 16'sd0, 15'd16384, 32'hffff_ffff);
				send_fields(1'b1, 1'b0, -16'sd16384, 16'sd0, 15'd16384, 32'h7fff_ffff);
				clock_ms = 32'h7fff_ffff;
			end else begin
				settle();
				case (phase)
					1: write_rates(20'd0, 20'hfffff);
					2: write_rates(20'hfffff, 20'd0);
					3: write_rates(20'hfffff, 20'hfffff);
					4: write_rates(20'($urandom), 20'($urandom));
					default: write_rates(20'd1, 20'd300000);
				endcase
			end
			repeat (90) send_word(make_cmd());
		end
		settle();
		if (score.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Run limit far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/ddmsl_pkg.sv
hdl/ddmsl_mix.sv
hdl/ddmsl_slew.sv
hdl/diff_drive_mixer_slew_limit_top.sv
sim/tb_diff_drive_mixer_slew_limit_top.sv
